[hw/rtl/bpcq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpcq_pkg
// Shared types, register indexes and reset values for the button press
// classifier queue.
// ----------------------------------------------------------------------------
package bpcq_pkg;

   // Fixed field widths.
   localparam int unsigned LEVEL_W  = 8;
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned COUNT_W  = 16;
   localparam int unsigned CSR_IDX_W = 2;

   // Default parameter values.
   localparam int unsigned NUM_BUTTONS_DEF = 8;
   localparam int unsigned QUEUE_DEPTH_DEF = 16;

   // Item operation codes.
   localparam logic OP_SCAN = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_TICKS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_TICKS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BEEP_TICKS    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GATHER_WINDOW = 2'd3;

   // Configuration reset values.
   localparam logic [COUNT_W-1:0] SHORT_TICKS_RST   = 16'd5;
   localparam logic [COUNT_W-1:0] LONG_TICKS_RST    = 16'd100;
   localparam logic [COUNT_W-1:0] BEEP_TICKS_RST    = 16'd10;
   localparam logic [COUNT_W-1:0] GATHER_WINDOW_RST = 16'd100;

   // Input item.
   typedef struct packed {
      logic               op;
      logic [LEVEL_W-1:0] buttons_high;
      logic [TIME_W-1:0]  now_ms;
   } req_type;

   // Result item.
   typedef struct packed {
      logic               beep_start;
      logic               beep_stop;
      logic               event_queued;
      logic               event_dropped;
      logic               pop_valid;
      logic [LEVEL_W-1:0] pop_mask;
      logic               pop_long;
   } rsp_type;

   // Configuration register set.
   typedef struct packed {
      logic [COUNT_W-1:0] short_ticks;
      logic [COUNT_W-1:0] long_ticks;
      logic [COUNT_W-1:0] beep_ticks;
      logic [COUNT_W-1:0] gather_window_ms;
   } cfg_type;

   // One queued event.
   typedef struct packed {
      logic               long_flag;
      logic [LEVEL_W-1:0] mask;
   } entry_type;

   // Push request from the scan logic to the queue.
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

   // Queue occupancy status.
   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

   // Scan result flags.
   typedef struct packed {
      logic beep_start;
      logic beep_stop;
      logic event_queued;
      logic event_dropped;
   } scan_flags_type;

endpackage

[hw/rtl/bpcq_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpcq_scan
// Per-button hold counters, press classification, beep timer and the
// gathering of classified presses into one pending event.
// ----------------------------------------------------------------------------
module bpcq_scan
   import bpcq_pkg::*;
#(
   parameter int unsigned NUM_BUTTONS = NUM_BUTTONS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               scan_en,
   input  logic [LEVEL_W-1:0] buttons_high,
   input  logic [TIME_W-1:0]  now_ms,
   input  cfg_type            cfg,
   input  qstat_type          q_stat,
   output push_type           push,
   output scan_flags_type     flags
);

   localparam int unsigned LANES = (NUM_BUTTONS < LEVEL_W) ? NUM_BUTTONS : LEVEL_W;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   logic [COUNT_W-1:0] hold_ff [LANES];
   logic [COUNT_W-1:0] hold_in [LANES];
   logic [LANES-1:0]   lane_mask;
   logic [LANES-1:0]   lane_long;
   logic [LANES-1:0]   lane_rose;

   logic [COUNT_W-1:0] beep_ff, beep_in, beep_dec;
   logic [LEVEL_W-1:0] pend_mask_ff, pend_mask_in, mask_merged, new_mask;
   logic               pend_long_ff, pend_long_in, long_merged;
   logic [TIME_W-1:0]  last_ff, last_in, last_merged, quiet_ms;
   logic               fire, start;

   // Per-lane classification and hold counter update.
   for (genvar i = 0; i < LANES; i++) begin : g_lane
      always_comb begin
         lane_mask[i] = 1'b0;
         lane_long[i] = 1'b0;
         lane_rose[i] = 1'b0;
         hold_in[i]   = hold_ff[i];
         if (buttons_high[i]) begin
            lane_mask[i] = (hold_ff[i] >= cfg.short_ticks) ||
                           (hold_ff[i] >= cfg.long_ticks);
            lane_long[i] = (hold_ff[i] >= cfg.long_ticks);
            hold_in[i]   = '0;
         end else if (hold_ff[i] != COUNT_MAX) begin
            hold_in[i]   = hold_ff[i] + 1'b1;
            lane_rose[i] = ((hold_ff[i] + 1'b1) == cfg.short_ticks);
         end
      end
   end

   // Beep timer: count down first, then a start reloads it.
   always_comb begin
      beep_dec = (beep_ff != '0) ? beep_ff - 1'b1 : '0;
      start    = (beep_dec == '0) && (|lane_rose);
      beep_in  = start ? cfg.beep_ticks : beep_dec;
   end

   // Merge new presses and decide whether the quiet window has passed.
   always_comb begin
      new_mask     = LEVEL_W'(lane_mask);
      mask_merged  = pend_mask_ff | new_mask;
      long_merged  = pend_long_ff | (|lane_long);
      last_merged  = (new_mask != '0) ? now_ms : last_ff;
      quiet_ms     = now_ms - last_merged;
      fire         = (mask_merged != '0) &&
                     (quiet_ms >= TIME_W'(cfg.gather_window_ms));
      pend_mask_in = fire ? '0 : mask_merged;
      pend_long_in = fire ? 1'b0 : long_merged;
      last_in      = last_merged;
   end

   // Push request and per-tick flags.
   always_comb begin
      push.valid           = scan_en && fire && !q_stat.full;
      push.entry.mask      = mask_merged;
      push.entry.long_flag = long_merged;
      flags.beep_start     = start;
      flags.beep_stop      = (beep_ff == COUNT_W'(1));
      flags.event_queued   = fire && !q_stat.full;
      flags.event_dropped  = fire && q_stat.full;
   end

   // State registers, updated on each accepted scan tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LANES; i++) begin
            hold_ff[i] <= '0;
         end
         beep_ff      <= '0;
         pend_mask_ff <= '0;
         pend_long_ff <= 1'b0;
         last_ff      <= '0;
      end else if (scan_en) begin
         for (int i = 0; i < LANES; i++) begin
            hold_ff[i] <= hold_in[i];
         end
         beep_ff      <= beep_in;
         pend_mask_ff <= pend_mask_in;
         pend_long_ff <= pend_long_in;
         last_ff      <= last_in;
      end
   end

endmodule

[hw/rtl/bpcq_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpcq_queue
// Circular event queue with one unused slot, held in a synchronous memory
// with registered read data.
// ----------------------------------------------------------------------------
module bpcq_queue
   import bpcq_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  push_type  push,
   input  logic      pop_en,
   output qstat_type q_stat,
   output entry_type rd_entry
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   entry_type        mem [QUEUE_DEPTH];
   entry_type        rd_entry_ff;
   logic [PTR_W-1:0] head_ff, head_in, tail_ff, tail_in, head_next, tail_next;
   logic             pop_ok;

   // Pointer arithmetic modulo the depth.
   always_comb begin
      head_next    = (head_ff == PTR_LAST) ? '0 : head_ff + 1'b1;
      tail_next    = (tail_ff == PTR_LAST) ? '0 : tail_ff + 1'b1;
      q_stat.empty = (head_ff == tail_ff);
      q_stat.full  = (head_next == tail_ff);
      pop_ok       = pop_en && !q_stat.empty;
      head_in      = push.valid ? head_next : head_ff;
      tail_in      = pop_ok ? tail_next : tail_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   // Memory write at the head and registered read at the tail. A push and
   // a pop never share a cycle, but a pop reads at the tail even when empty.
   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem[head_ff] <= push.entry;
      end
      if (pop_en) begin
         rd_entry_ff <= mem[tail_ff];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

[hw/rtl/button_press_classifier_queue_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_press_classifier_queue_unit
// Classifies button presses as short or long, drives a beep timer and
// queues merged press events for a later pop.
// ----------------------------------------------------------------------------
// Usage:
// Each transfer on the req_ channel is either a scan tick (op scan) with the
// active-low button levels and a millisecond timestamp, or a pop (op pop).
// Every request yields exactly one transfer on the rsp_ channel, in order.
// A result is registered in the output register in the cycle after its
// request is taken; while req_stall is low a new request can be taken every
// cycle, so throughput is one item per clock. Popped events are read from the
// queue memory through its registered read port.
// When the receiver asserts rsp_stall while a result is held, req_stall rises
// in the same cycle and the held result stays unchanged until it is taken.
// The csr_ channel is always ready and writes one configuration register per
// transfer; write it only while the block is idle.
// A synchronous reset clears the hold counters, beep timer, pending event and
// queue pointers, and restores the configuration defaults. It needs no
// clearing pass: popped data is masked unless the queue held an entry.
// ----------------------------------------------------------------------------
module button_press_classifier_queue_unit
   import bpcq_pkg::*;
#(
   parameter int unsigned NUM_BUTTONS = NUM_BUTTONS_DEF,
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COUNT_W-1:0]   csr_wdata
);

   cfg_type        cfg_ff;
   push_type       push;
   qstat_type      q_stat;
   scan_flags_type flags, flags_ff;
   entry_type      rd_entry;
   logic           req_fire, scan_en, pop_en;
   logic           rsp_valid_ff, rsp_valid_in, pop_valid_ff;

   // Request acceptance: stall only while a held result is not taken.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;
   assign scan_en   = req_fire && (req_payload.op == OP_SCAN);
   assign pop_en    = req_fire && (req_payload.op == OP_POP);

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_ticks      <= SHORT_TICKS_RST;
         cfg_ff.long_ticks       <= LONG_TICKS_RST;
         cfg_ff.beep_ticks       <= BEEP_TICKS_RST;
         cfg_ff.gather_window_ms <= GATHER_WINDOW_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SHORT_TICKS:   cfg_ff.short_ticks      <= csr_wdata;
            CSR_LONG_TICKS:    cfg_ff.long_ticks       <= csr_wdata;
            CSR_BEEP_TICKS:    cfg_ff.beep_ticks       <= csr_wdata;
            CSR_GATHER_WINDOW: cfg_ff.gather_window_ms <= csr_wdata;
            default:           cfg_ff                  <= cfg_ff;
         endcase
      end
   end

   // Scan logic.
   bpcq_scan #(
      .NUM_BUTTONS (NUM_BUTTONS)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .scan_en      (scan_en),
      .buttons_high (req_payload.buttons_high),
      .now_ms       (req_payload.now_ms),
      .cfg          (cfg_ff),
      .q_stat       (q_stat),
      .push         (push),
      .flags        (flags)
   );

   // Event queue.
   bpcq_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .pop_en   (pop_en),
      .q_stat   (q_stat),
      .rd_entry (rd_entry)
   );

   // Output register: valid is set by a request transfer, cleared by a take.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         flags_ff     <= scan_en ? flags : '0;
         pop_valid_ff <= pop_en && !q_stat.empty;
      end
   end

   // Result assembly; the popped entry comes from the registered memory read.
   always_comb begin
      rsp_payload.beep_start    = flags_ff.beep_start;
      rsp_payload.beep_stop     = flags_ff.beep_stop;
      rsp_payload.event_queued  = flags_ff.event_queued;
      rsp_payload.event_dropped = flags_ff.event_dropped;
      rsp_payload.pop_valid     = pop_valid_ff;
      rsp_payload.pop_mask      = pop_valid_ff ? rd_entry.mask : '0;
      rsp_payload.pop_long      = pop_valid_ff ? rd_entry.long_flag : 1'b0;
   end

   assign rsp_valid = rsp_valid_ff;

   // A push always leaves the queue non-empty.
   a_push_not_empty : assert property (@(posedge clock) disable iff (reset)
      (req_fire && push.valid) |=> !q_stat.empty)
      else $error("queue empty after a push");

   // A pop from an empty queue never reports an event.
   a_empty_pop : assert property (@(posedge clock) disable iff (reset)
      (pop_en && q_stat.empty) |=> !rsp_payload.pop_valid)
      else $error("pop of empty queue returned an event");

   // An event is never both queued and dropped.
   a_queued_xor_dropped : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.event_queued && rsp_payload.event_dropped))
      else $error("event both queued and dropped");

   // A pop result carries no scan flags.
   a_pop_no_scan : assert property (@(posedge clock) disable iff (reset)
      (pop_en |=> !(rsp_payload.beep_start || rsp_payload.beep_stop ||
                    rsp_payload.event_queued || rsp_payload.event_dropped)))
      else $error("scan flags set on a pop result");

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the button press classifier queue. A directed table
// walks reset behavior, press classification, the beep timer, the quiet
// window with timestamp wrap, queue full and empty cases, a beep of zero
// length and zero thresholds. Random phases follow with press sequences, pops
// and noise under several threshold settings. Every result transfer is
// compared field by field against the typed value of its table row, if it has
// one, or else against a cycle-free model of the block kept in this file.
// ----------------------------------------------------------------------------
module testbench;
   import bpcq_pkg::*;

   localparam int          QDEPTH       = QUEUE_DEPTH_DEF;
   localparam int          NUM_LANES    = (NUM_BUTTONS_DEF < LEVEL_W) ? NUM_BUTTONS_DEF : LEVEL_W;
   localparam int          CYCLE_LIMIT  = 1000000;
   localparam int          PHASE_ITEMS  = 200;
   localparam int          NUM_PHASES   = 5;
   localparam int          NUM_ROWS     = 35;
   localparam int          IDLE_MAX     = 17;

   localparam rsp_type RSP_NONE    = '0;
   localparam rsp_type RSP_QUEUED  = '{event_queued: 1'b1, default: '0};
   localparam rsp_type RSP_DROPPED = '{event_dropped: 1'b1, default: '0};
   localparam cfg_type CFG_NONE    = '0;

   typedef enum logic {ROW_SEND, ROW_CONFIG} row_kind_type;

   // One line of the directed stimulus table.
   typedef struct {
      row_kind_type       kind;
      logic               op;
      logic [LEVEL_W-1:0] levels;
      logic [TIME_W-1:0]  now_ms;
      int                 reps;
      bit                 burst;
      bit                 has_typed;
      rsp_type            rsp;
      cfg_type            cfg;
   } stim_row_type;

   // Directed table. Rows with a typed result are checked against that value.
   stim_row_type directed_rows [NUM_ROWS] = '{
      // Defaults after reset: empty pop, idle scan, then presses of every kind.
      '{ROW_SEND,   OP_POP,  8'hFF, 32'h0000_0000,     1, 1'b0, 1'b1, RSP_NONE,    CFG_NONE},
      '{ROW_SEND,   OP_SCAN, 8'hFF, 32'h0000_0000,     1, 1'b0, 1'b1, RSP_NONE,    CFG_NONE},
      '{ROW_SEND,   OP_SCAN, 8'h00, 32'h0000_0000,     4, 1'b0, 1'b0, RSP_NONE,    CFG_NONE},
      '{ROW_SEND,   OP_SCAN, 8'h00, 32'h0000_0001,     1, 1'b0, 1'b0, RSP_NONE,    CFG_NONE},
      '{ROW_SEND,   OP_SCAN, 8'h00, 32'h0000_0002,   120, 1'b0, 1'b0, RSP_NONE,    CFG_NONE},
      '{ROW_SEND,   OP_SCAN, 8'hFE, 32'd200,           1, 1'b0, 1'b0, RSP_NONE,    CFG_NONE},
      '{ROW_SEND,   OP_SCAN, 8'hFF, 32'd250,           1, 1'b0, 1'b0, RSP_NONE,    CFG_NONE},
      '{ROW_SEND,   OP_SCAN, 8'hFF, 32'd349,           1, 1'b0, 1'b0, RSP_NONE,    CFG_NONE},
      '{ROW_SEND,   OP_SCAN, 8'hFF, 32'd350,           1, 1'b0, 1'b0, RSP_NONE,    CFG_NONE},
      '{ROW_SEND,   OP_SCAN, 8'hFD, 32'd400,           7, 1'b0, 1'b0, RSP_NONE,    CFG_NONE},
      '{ROW_SEND,   OP_SCAN, 8'hFF, 32'd410,           1, 1'b0, 1'b0, RSP_NONE,    CFG_NONE},
      '{ROW_SEND,   OP_SCAN, 8'hFB, 32'd420,           2, 1'b0, 1'b0, RSP_NONE,    CFG_NONE},
      '{ROW_SEND,   OP_SCAN, 8'hFF, 32'd430,           1, 1'b0, 1'b0, RSP_NONE,    CFG_NONE},
      // Quiet window measured across the timestamp wrap.
      '{ROW_SEND,   OP_SCAN, 8'h7F, 32'hFFFF_FFF0,     6, 1'b0, 1'b0, RSP_NONE,    CFG_NONE},
      '{ROW_SEND,   OP_SCAN, 8'hFF, 32'hFFFF_FFFF,     1, 1'b0, 1'b0, RSP_NONE,    CFG_NONE},
      '{ROW_SEND,   OP_SCAN, 8'hFF, 32'h0000_0062,     1, 1'b0, 1'b0, RSP_NONE,    CFG_NONE},
      '{ROW_SEND,   OP_SCAN, 8'hFF, 32'h0000_0063,     1, 1'b0, 1'b0, RSP_NONE,    CFG_NONE},
      '{ROW_SEND,   OP_POP,  8'h00, 32'h0000_0000,     3, 1'b0, 1'b0, RSP_NONE,    CFG_NONE},
      '{ROW_SEND,   OP_POP,  8'h00, 32'hFFFF_FFFF,     1, 1'b0, 1'b1, RSP_NONE,    CFG_NONE},
      // Zero thresholds: every released button classifies on every tick.
      '{ROW_CONFIG, OP_SCAN, 8'h00, 32'h0000_0000,     0, 1'b0, 1'b0, RSP_NONE,
        {16'd0, 16'd0, 16'd0, 16'd0}},
      '{ROW_SEND,   OP_SCAN, 8'hFF, 32'h0000_0000,     1, 1'b0, 1'b1, RSP_QUEUED,  CFG_NONE},
      '{ROW_SEND,   OP_SCAN, 8'hFF, 32'h0000_0000,    14, 1'b0, 1'b0, RSP_NONE,    CFG_NONE},
      '{ROW_SEND,   OP_SCAN, 8'hFF, 32'h0000_0001,     3, 1'b0, 1'b1, RSP_DROPPED, CFG_NONE},
      '{ROW_SEND,   OP_POP,  8'hFF, 32'h0000_0000,    15, 1'b0, 1'b0, RSP_NONE,    CFG_NONE},
      '{ROW_SEND,   OP_POP,  8'h00, 32'h0000_0000,     1, 1'b0, 1'b1, RSP_NONE,    CFG_NONE},
      // Largest long threshold and a zero beep length: a start with no stop.
      '{ROW_CONFIG, OP_SCAN, 8'h00, 32'h0000_0000,     0, 1'b0, 1'b0, RSP_NONE,
        {16'd30, 16'hFFFF, 16'd0, 16'd0}},
      '{ROW_SEND,   OP_SCAN, 8'hFE, 32'h0000_0005,    40, 1'b1, 1'b0, RSP_NONE,    CFG_NONE},
      '{ROW_SEND,   OP_SCAN, 8'hFF, 32'hFFFF_FFFF,     1, 1'b0, 1'b0, RSP_NONE,    CFG_NONE},
      '{ROW_SEND,   OP_POP,  8'h00, 32'h0000_0000,     1, 1'b0, 1'b0, RSP_NONE,    CFG_NONE},
      // One-tick beep: start and stop land on the same scan; longest window.
      '{ROW_CONFIG, OP_SCAN, 8'h00, 32'h0000_0000,     0, 1'b0, 1'b0, RSP_NONE,
        {16'd2, 16'd3, 16'd1, 16'hFFFF}},
      '{ROW_SEND,   OP_SCAN, 8'hFE, 32'h0000_0000,     1, 1'b0, 1'b0, RSP_NONE,    CFG_NONE},
      '{ROW_SEND,   OP_SCAN, 8'hFC, 32'h0000_0001,     2, 1'b0, 1'b0, RSP_NONE,    CFG_NONE},
      '{ROW_SEND,   OP_SCAN, 8'hFF, 32'h0000_0005,     1, 1'b0, 1'b0, RSP_NONE,    CFG_NONE},
      '{ROW_SEND,   OP_SCAN, 8'hFF, 32'h0001_0004,     1, 1'b0, 1'b0, RSP_NONE,    CFG_NONE},
      '{ROW_SEND,   OP_POP,  8'h00, 32'h0000_0000,     1, 1'b0, 1'b0, RSP_NONE,    CFG_NONE}
   };

   // Block ports.
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b1;
   rsp_type              rsp_payload;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_SHORT_TICKS;
   logic [COUNT_W-1:0]   csr_wdata = '0;

   // Model state of the classifier and its event ring.
   cfg_type              thresholds = {SHORT_TICKS_RST, LONG_TICKS_RST, BEEP_TICKS_RST,
                                       GATHER_WINDOW_RST};
   logic [COUNT_W-1:0]   press_ticks [NUM_LANES] = '{default: '0};
   logic [COUNT_W-1:0]   beep_remaining = '0;
   logic [LEVEL_W-1:0]   merged_mask = '0;
   logic                 merged_long = 1'b0;
   logic [TIME_W-1:0]    last_release_ms = '0;
   entry_type            event_ring [QDEPTH] = '{default: '0};
   int unsigned          ring_wr = 0;
   int unsigned          ring_rd = 0;

   // Results predicted for accepted requests, oldest first.
   rsp_type              predicted_rsp_q [$];

   // Run bookkeeping.
   int                   cycle_count = 0;
   int                   error_count = 0;
   int                   results_checked = 0;
   int                   events_queued = 0;
   int                   events_dropped = 0;
   int                   pops_returned = 0;
   int                   beeps_started = 0;
   int                   directed_items = 0;
   int                   random_items = 0;
   int                   req_gap_max = 3;
   int                   rsp_gap_max = 3;
   int                   hold_off_cycles = 0;

   // Stimulus state for well-formed press sequences.
   logic [LEVEL_W-1:0]   held_levels = 8'hFF;
   logic [TIME_W-1:0]    scan_ms = '0;

   button_press_classifier_queue_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Works out the result of one request and advances the model state.
   function automatic rsp_type classify_item(req_type item);
      rsp_type            res;
      logic [LEVEL_W-1:0] new_mask;
      logic               new_long;
      logic [COUNT_W-1:0] cnt;
      logic [TIME_W-1:0]  quiet_ms;
      int unsigned        next_wr;
      int                 i;
      res = '0;
      new_mask = '0;
      new_long = 1'b0;
      if (item.op == OP_POP) begin
         if (ring_wr != ring_rd) begin
            res.pop_valid = 1'b1;
            res.pop_mask  = event_ring[ring_rd].mask;
            res.pop_long  = event_ring[ring_rd].long_flag;
            ring_rd = (ring_rd + 1) % QDEPTH;
         end
      end else begin
         // The beep timer counts down before the lanes are looked at.
         if (beep_remaining != 0) begin
            beep_remaining = beep_remaining - 1'b1;
            if (beep_remaining == 0) begin
               res.beep_stop = 1'b1;
            end
         end
         // Lanes in order; a beep started by a lower lane blocks higher ones.
         for (i = 0; i < NUM_LANES; i++) begin
            cnt = press_ticks[i];
            if (item.buttons_high[i]) begin
               if (cnt >= thresholds.long_ticks) begin
                  new_mask[i] = 1'b1;
                  new_long = 1'b1;
               end else if (cnt >= thresholds.short_ticks) begin
                  new_mask[i] = 1'b1;
               end
               press_ticks[i] = '0;
            end else if (cnt != 16'hFFFF) begin
               cnt = cnt + 1'b1;
               press_ticks[i] = cnt;
               if (beep_remaining == 0 && cnt == thresholds.short_ticks) begin
                  beep_remaining = thresholds.beep_ticks;
                  res.beep_start = 1'b1;
               end
            end
         end
         if (new_mask != 0) begin
            merged_mask = merged_mask | new_mask;
            merged_long = merged_long | new_long;
            last_release_ms = item.now_ms;
         end
         // Push the merged event once the quiet window has passed.
         quiet_ms = item.now_ms - last_release_ms;
         if (merged_mask != 0 && quiet_ms >= {16'd0, thresholds.gather_window_ms}) begin
            next_wr = (ring_wr + 1) % QDEPTH;
            if (next_wr != ring_rd) begin
               event_ring[ring_wr] = '{long_flag: merged_long, mask: merged_mask};
               ring_wr = next_wr;
               res.event_queued = 1'b1;
            end else begin
               res.event_dropped = 1'b1;
            end
            merged_mask = '0;
            merged_long = 1'b0;
         end
      end
      return res;
   endfunction

   function automatic int draw_gap(int max_gap);
      if (max_gap == 0 || $urandom_range(0, 2) == 0) begin
         return 0;
      end
      return $urandom_range(0, max_gap);
   endfunction

   // Offers one request and records its predicted result once it transfers.
   task automatic send_item(req_type item, bit has_typed, rsp_type typed_rsp);
      int      gap;
      rsp_type prediction;
      gap = draw_gap(req_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      prediction = classify_item(item);
      if (has_typed) begin
         prediction = typed_rsp;
      end
      predicted_rsp_q.push_back(prediction);
   endtask

   // Drops valid and waits until every outstanding result has arrived.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (predicted_rsp_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] index, logic [COUNT_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_SHORT_TICKS:   thresholds.short_ticks = value;
         CSR_LONG_TICKS:    thresholds.long_ticks = value;
         CSR_BEEP_TICKS:    thresholds.beep_ticks = value;
         CSR_GATHER_WINDOW: thresholds.gather_window_ms = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Thresholds change only once the block has gone idle.
   task automatic program_thresholds(cfg_type setting);
      drain_results();
      write_csr(CSR_SHORT_TICKS, setting.short_ticks);
      write_csr(CSR_LONG_TICKS, setting.long_ticks);
      write_csr(CSR_BEEP_TICKS, setting.beep_ticks);
      write_csr(CSR_GATHER_WINDOW, setting.gather_window_ms);
   endtask

   // Mostly held-button sequences with a steady clock, plus pops and noise.
   task automatic run_random_phase(int phase);
      cfg_type setting;
      req_type item;
      int      n;
      int      i;
      int      roll;
      case (phase)
         0: setting = {16'd3, 16'd12, 16'd4, 16'd10};
         2: setting = {16'd1, 16'd1, 16'hFFFF, 16'd0};
         default: begin
            setting.short_ticks      = COUNT_W'($urandom_range(1, 6));
            setting.long_ticks       = setting.short_ticks + COUNT_W'($urandom_range(0, 15));
            setting.beep_ticks       = COUNT_W'($urandom_range(0, 12));
            setting.gather_window_ms = COUNT_W'($urandom_range(0, 40));
         end
      endcase
      program_thresholds(setting);
      if (phase == 1) begin
         scan_ms = 32'hFFFF_FF00;
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
         // Switch between idling and back-to-back stretches.
         if (n % 40 == 0) begin
            req_gap_max = ($urandom_range(0, 2) == 0) ? 0 : IDLE_MAX;
            rsp_gap_max = ($urandom_range(0, 2) == 0) ? 0 : IDLE_MAX;
         end
         // Receiver holds off while the sender keeps offering.
         if (phase == 3 && n == 100) begin
            hold_off_cycles = 150;
         end
         if (phase == 3 && n >= 100 && n < 140) begin
            req_gap_max = 0;
         end
         // Sender waits until all results are back.
         if (phase == 4 && n == 125) begin
            drain_results();
         end
         roll = $urandom_range(0, 99);
         if (roll < 20) begin
            item.op           = OP_POP;
            item.buttons_high = LEVEL_W'($urandom);
            item.now_ms       = $urandom;
         end else if (roll < 24) begin
            item.op           = OP_SCAN;
            item.buttons_high = LEVEL_W'($urandom);
            item.now_ms       = $urandom;
         end else begin
            for (i = 0; i < LEVEL_W; i++) begin
               if ($urandom_range(0, 7) == 0) begin
                  held_levels[i] = ~held_levels[i];
               end
            end
            if ($urandom_range(0, 29) == 0) begin
               scan_ms = scan_ms + $urandom_range(20, 300);
            end else begin
               scan_ms = scan_ms + $urandom_range(0, 5);
            end
            item.op           = OP_SCAN;
            item.buttons_high = held_levels;
            item.now_ms       = scan_ms;
         end
         send_item(item, 1'b0, RSP_NONE);
         random_items++;
      end
   endtask

   // Result side stalls for a drawn number of cycles before each transfer.
   always begin : result_receiver
      int wait_cycles;
      @(negedge clock);
      if (hold_off_cycles != 0) begin
         wait_cycles = hold_off_cycles;
         hold_off_cycles = 0;
      end else begin
         wait_cycles = draw_gap(rsp_gap_max);
      end
      if (wait_cycles > 0) begin
         rsp_stall <= 1'b1;
         repeat (wait_cycles) @(negedge clock);
      end
      rsp_stall <= 1'b0;
      do @(posedge clock); while (!(rsp_valid && !rsp_stall));
   end

   task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
      end
   endtask

   // Each result transfer is checked against the oldest prediction.
   always @(posedge clock) begin : result_checker
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_rsp_q.size() == 0) begin
            error_count++;
            $display("%0t: result with no prediction waiting, actual %p", $time, rsp_payload);
         end else begin
            want = predicted_rsp_q.pop_front();
            compare_field("beep_start", 32'(want.beep_start),
                          32'(rsp_payload.beep_start));
            compare_field("beep_stop", 32'(want.beep_stop),
                          32'(rsp_payload.beep_stop));
            compare_field("event_queued", 32'(want.event_queued),
                          32'(rsp_payload.event_queued));
            compare_field("event_dropped", 32'(want.event_dropped),
                          32'(rsp_payload.event_dropped));
            compare_field("pop_valid", 32'(want.pop_valid),
                          32'(rsp_payload.pop_valid));
            compare_field("pop_mask", 32'(want.pop_mask),
                          32'(rsp_payload.pop_mask));
            compare_field("pop_long", 32'(want.pop_long),
                          32'(rsp_payload.pop_long));
            results_checked++;
            events_queued  += want.event_queued;
            events_dropped += want.event_dropped;
            pops_returned  += want.pop_valid;
            beeps_started  += want.beep_start;
         end
      end
   end

   // Watchdog on the whole run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Timeout after %0d cycles, %0d results still outstanding", cycle_count,
               predicted_rsp_q.size());
      $display("FAIL");
      $finish;
   end

   initial begin
      req_type item;
      int      k;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table.
      for (k = 0; k < NUM_ROWS; k++) begin
         if (directed_rows[k].kind == ROW_CONFIG) begin
            program_thresholds(directed_rows[k].cfg);
         end else begin
            req_gap_max = directed_rows[k].burst ? 0 : 3;
            rsp_gap_max = directed_rows[k].burst ? 0 : 3;
            item.op           = directed_rows[k].op;
            item.buttons_high = directed_rows[k].levels;
            item.now_ms       = directed_rows[k].now_ms;
            repeat (directed_rows[k].reps) begin
               send_item(item, directed_rows[k].has_typed, directed_rows[k].rsp);
               directed_items++;
            end
         end
      end

      // Random phases under changing thresholds.
      for (k = 0; k < NUM_PHASES; k++) begin
         run_random_phase(k);
      end

      drain_results();
      repeat (8) @(posedge clock);
      $display("Checked %0d results from %0d directed and %0d random requests.",
               results_checked, directed_items, random_items);
      $display("Events queued %0d, dropped %0d, popped %0d; beeps started %0d.",
               events_queued, events_dropped, pops_returned, beeps_started);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[button_press_classifier_queue_unit.f]
hw/rtl/bpcq_pkg.sv
hw/rtl/bpcq_scan.sv
hw/rtl/bpcq_queue.sv
hw/rtl/button_press_classifier_queue_unit.sv
test/testbench.sv
